// ===== rtl/lbf_pkg.sv =====
`default_nettype none

package lbf_pkg;

	localparam int MAX_RADIUS  = 15;
	localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
	localparam int PIX_W       = 8;
	localparam int RAD_W       = 4;
	localparam int TAP_W       = $clog2(WIN_DEPTH);
	localparam int CNT_W       = 5;
	localparam int SUM_W       = 13;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// Shift or preload command for the window cells.
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [PIX_W-1:0] pix;
	} win_ctl_t;

	// Rounded-up 2^21 / (2r + 1). With sums below 2^13 the product shifted right
	// by 21 bits is the exact truncated quotient.
	function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
		logic [RECIP_W-1:0] m;
		case (r)
			4'd1:    m = RECIP_W'(699051);
			4'd2:    m = RECIP_W'(419431);
			4'd3:    m = RECIP_W'(299594);
			4'd4:    m = RECIP_W'(233017);
			4'd5:    m = RECIP_W'(190651);
			4'd6:    m = RECIP_W'(161320);
			4'd7:    m = RECIP_W'(139811);
			4'd8:    m = RECIP_W'(123362);
			4'd9:    m = RECIP_W'(110377);
			4'd10:   m = RECIP_W'(99865);
			4'd11:   m = RECIP_W'(91181);
			4'd12:   m = RECIP_W'(83887);
			4'd13:   m = RECIP_W'(77673);
			4'd14:   m = RECIP_W'(72316);
			4'd15:   m = RECIP_W'(67651);
			default: m = RECIP_W'(2097152);
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lbf_cell.sv =====
`default_nettype none

module lbf_cell import lbf_pkg::*; (
	input  logic             clk,
	input  win_ctl_t         ctl,
	input  logic [PIX_W-1:0] prev,
	output logic [PIX_W-1:0] data
);

	logic [PIX_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= ctl.pix;
		end else if (ctl.shift) begin
			data_q <= prev;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== rtl/lbf_window.sv =====
`default_nettype none

module lbf_window import lbf_pkg::*; (
	input  logic             clk,
	input  win_ctl_t         ctl,
	input  logic [TAP_W-1:0] tap_sel,
	output logic [PIX_W-1:0] tail
);

	logic [PIX_W-1:0] cell_data [WIN_DEPTH];

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			lbf_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.prev (ctl.pix),
				.data (cell_data[i])
			);
		end else begin : g_body
			lbf_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.prev (cell_data[i-1]),
				.data (cell_data[i])
			);
		end
	end

	// The oldest sample of the active window sits in cell 2r.
	assign tail = cell_data[tap_sel];

endmodule

`default_nettype wire

// ===== rtl/lbf_div.sv =====
`default_nettype none

module lbf_div import lbf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] sum,
	input  logic [RAD_W-1:0] radius,
	output logic [PIX_W-1:0] quot
);

	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(sum) * PROD_W'(recip(radius));
		end
	end

	assign quot = prod_s2[RECIP_SHIFT +: PIX_W];

endmodule

`default_nettype wire

// ===== rtl/line_box_filter.sv =====
// Streaming 1-D box filter over one line of 8-bit pixels with replicated borders.
// Slave side: one pixel per beat in s_tdata, s_tlast on the final pixel of a line.
// Master side: one window mean per beat in m_tdata; m_tuser marks the last result
// caused by an input beat, m_tlast the final result of the line.
// cfg_we/cfg_wdata set the radius r (0..15, window 2r+1); a write starts a new line.
// Throughput: one pixel per cycle while s_tready is high. The result for position p
// follows the beat of pixel p+r; a line of n pixels gives n results. After the last
// pixel the window cell chain makes r more shifts to flush the line end, during
// which s_tready is low.
// Pipeline: window/sum update, reciprocal multiply, then the output register that
// drives m_tvalid; a result passes through them in that order.
// Reset clears the pipeline, sets the radius to 1 and starts a new line.
// When m_tready is low the output beat holds; the stages behind it keep filling
// their empty slots and, outside a flush, s_tready drops only when every slot holds a result.
`default_nettype none

module line_box_filter import lbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] filtered
	output logic             m_tuser,   // [0] run_last
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [RAD_W-1:0] cfg_wdata
);

	logic [RAD_W-1:0] radius_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flush_q;
	logic [RAD_W-1:0] rem_q;
	logic [PIX_W-1:0] last_pix_q;

	logic [SUM_W-1:0] sum_s1;
	logic             v_s1, run_last_s1, line_end_s1;
	logic             v_s2, run_last_s2, line_end_s2;

	logic             m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [PIX_W-1:0] m_tdata_q;

	logic             out_en, s2_en, s1_en, step, start;
	logic [PIX_W-1:0] pix, tail, quot;
	logic [CNT_W-1:0] cnt_inc, r_plus, cnt_sat, cnt_next;
	logic             emit, flush_end, run_last_d, line_end_d;
	logic [SUM_W-1:0] sum_next;
	win_ctl_t         win_ctl;

	assign out_en = !m_tvalid_q || m_tready;
	assign s2_en  = !v_s2 || out_en;
	assign s1_en  = !v_s1 || s2_en;

	assign s_tready = s1_en && !flush_q;
	assign step     = s1_en && (flush_q || s_tvalid);
	assign start    = !flush_q && (cnt_q == '0);
	assign pix      = flush_q ? last_pix_q : s_tdata[PIX_W-1:0];

	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign r_plus    = CNT_W'(radius_q) + CNT_W'(1);
	assign emit      = cnt_inc >= r_plus;
	assign cnt_sat   = emit ? r_plus : cnt_inc;
	assign flush_end = flush_q && (rem_q == RAD_W'(1));

	// A new line preloads the whole window with its first pixel.
	always_comb begin
		if (start) begin
			sum_next = SUM_W'({radius_q, 1'b1}) * SUM_W'(pix);
		end else begin
			sum_next = sum_s1 + SUM_W'(pix) - SUM_W'(tail);
		end
	end

	// Flags and line position that one step leaves behind.
	always_comb begin
		run_last_d = 1'b0;
		line_end_d = 1'b0;
		cnt_next   = cnt_sat;
		if (flush_q) begin
			run_last_d = flush_end;
			line_end_d = flush_end;
			if (flush_end) begin
				cnt_next = '0;
			end
		end else if (s_tlast) begin
			if (radius_q == '0) begin
				run_last_d = 1'b1;
				line_end_d = 1'b1;
				cnt_next   = '0;
			end
		end else begin
			run_last_d = emit;
		end
	end

	always_comb begin
		win_ctl.shift = step && !start;
		win_ctl.load  = step && start;
		win_ctl.pix   = pix;
	end

	lbf_window u_window (
		.clk     (clk),
		.ctl     (win_ctl),
		.tap_sel ({radius_q, 1'b0}),
		.tail    (tail)
	);

	lbf_div u_div (
		.clk    (clk),
		.en     (s2_en),
		.sum    (sum_s1),
		.radius (radius_q),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (step) begin
			sum_s1 <= sum_next;
			if (!flush_q) begin
				last_pix_q <= pix;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RAD_W'(1);
			cnt_q       <= '0;
			flush_q     <= 1'b0;
			rem_q       <= '0;
			v_s1        <= 1'b0;
			run_last_s1 <= 1'b0;
			line_end_s1 <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1        <= step && emit;
				run_last_s1 <= step && run_last_d;
				line_end_s1 <= step && line_end_d;
			end
			if (cfg_we) begin
				radius_q <= cfg_wdata;
				cnt_q    <= '0;
			end else if (step) begin
				cnt_q <= cnt_next;
			end
			if (step) begin
				if (flush_q) begin
					rem_q <= rem_q - RAD_W'(1);
					if (flush_end) begin
						flush_q <= 1'b0;
					end
				end else if (s_tlast && (radius_q != '0)) begin
					flush_q <= 1'b1;
					rem_q   <= radius_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			run_last_s2 <= 1'b0;
			line_end_s2 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (s2_en) begin
				v_s2        <= v_s1;
				run_last_s2 <= run_last_s1;
				line_end_s2 <= line_end_s1;
			end
			if (out_en) begin
				m_tvalid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			m_tdata_q <= quot;
			m_tuser_q <= run_last_s2;
			m_tlast_q <= line_end_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ===== tb/sv/lbf_checker.sv =====
`timescale 1ns / 100ps

module lbf_checker import lbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel
	input  logic             s_tlast,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [7:0]       m_tdata,   // [7:0] filtered
	input  logic             m_tuser,   // [0] run_last
	input  logic             m_tlast,
	input  logic             cfg_we,
	input  logic [RAD_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	typedef struct packed {
		logic [PIX_W-1:0] filtered;
		logic             run_last;
		logic             line_end;
	} mean_beat_t;

	mean_beat_t       means_q[$];
	logic [RAD_W-1:0] radius;
	logic [PIX_W-1:0] win [WIN_DEPTH];
	logic [SUM_W-1:0] win_sum;
	logic [CNT_W-1:0] seen;

	function automatic void slide_window(input int len, input logic [PIX_W-1:0] pix);
		win_sum = win_sum + SUM_W'(pix) - SUM_W'(win[len-1]);
		for (int i = len - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = pix;
	endfunction

	// Updates the line state for one pixel beat and queues every mean it releases.
	function automatic void take_pixel(input logic [PIX_W-1:0] pix, input logic last);
		int               r;
		int               len;
		int               cnt;
		logic [PIX_W-1:0] means[$];
		mean_beat_t       beat;
		r = (int'(radius) > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
		len = 2 * r + 1;
		// A new line starts with the window full of its first pixel.
		if (seen == 0) begin
			for (int i = 0; i < len; i++)
				win[i] = pix;
			win_sum = SUM_W'(len * int'(pix));
		end
		slide_window(len, pix);
		cnt = int'(seen) + 1;
		if (cnt >= r + 1)
			means.push_back(PIX_W'(win_sum / SUM_W'(len)));
		if (last) begin
			// The last pixel is replicated past the line end to flush the rest.
			for (int i = 0; i < r; i++) begin
				slide_window(len, pix);
				cnt++;
				if (cnt >= r + 1)
					means.push_back(PIX_W'(win_sum / SUM_W'(len)));
			end
			seen = '0;
		end else begin
			seen = CNT_W'((cnt > r + 1) ? r + 1 : cnt);
		end
		for (int i = 0; i < means.size(); i++) begin
			beat.filtered = means[i];
			beat.run_last = (i == means.size() - 1);
			beat.line_end = last && (i == means.size() - 1);
			means_q.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mean_beat_t want;
		if (!arst_n) begin
			radius = RAD_W'(1);
			win_sum = '0;
			seen = '0;
			for (int i = 0; i < WIN_DEPTH; i++)
				win[i] = '0;
			means_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			// A radius write abandons the line in progress.
			if (cfg_we) begin
				radius = cfg_wdata;
				seen = '0;
			end
			if (s_tvalid && s_tready)
				take_pixel(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (means_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected: filtered=%0d run_last=%b line_end=%b",
							$realtime, m_tdata, m_tuser, m_tlast);
				end else begin
					want = means_q.pop_front();
					if (m_tdata !== want.filtered || m_tuser !== want.run_last ||
							m_tlast !== want.line_end) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: result %0d expected filtered=%0d run_last=%b line_end=%b, got filtered=%0d run_last=%b line_end=%b",
								$realtime, checked, want.filtered, want.run_last, want.line_end,
								m_tdata, m_tuser, m_tlast);
					end
					checked++;
				end
			end
			pending = means_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_line_box_filter.sv =====
`timescale 1ns / 100ps

module tb_line_box_filter;
	import lbf_pkg::*;

	localparam int DRAIN = 8;
	localparam int LIMIT = 500000;
	localparam int ITEMS = 220;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;   // [7:0] pixel
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // [7:0] filtered
	logic             m_tuser;   // [0] run_last
	logic             m_tlast;
	logic             cfg_we;
	logic [RAD_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int checked;
	int cycles;
	int pixels_sent;
	int lines_sent;
	int radius_writes;
	int rx_hold;
	bit tx_fast;
	bit rx_fast;

	line_box_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lbf_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
			$display("line_box_filter test failed");
			$finish;
		end
	end

	// Offers one pixel beat after an optional gap; valid stays high into the next beat.
	task automatic send_beat(input logic [7:0] pix, input logic last);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (last)
			lines_sent++;
	endtask

	// Stops offering pixels and waits until every queued mean has come out.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_radius(input logic [RAD_W-1:0] r);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
		radius_writes++;
	endtask

	// Sends a line of random content; a line left open is abandoned by the next write.
	task automatic send_line(input int len, input bit close);
		int         look;
		logic [7:0] pix;
		look = $urandom_range(0, 7);
		for (int i = 0; i < len; i++) begin
			case (look)
				0:       pix = 8'hFF;
				1:       pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2:       pix = 8'(120 + $urandom_range(0, 15));
				default: pix = 8'($urandom_range(0, 255));
			endcase
			send_beat(pix, close && (i == len - 1));
		end
	endtask

	// Result side: a random stall before each beat, or a long hold when asked for.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0)
				stall = rx_hold;
			else
				stall = rx_fast ? 0 : $urandom_range(0, 10);
			rx_hold = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int               lines;
		int               len;
		logic [RAD_W-1:0] r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		pixels_sent = 0;
		lines_sent = 0;
		radius_writes = 0;
		rx_hold = 0;
		tx_fast = 1'b0;
		rx_fast = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Radius after reset, full-scale swings and a one-pixel line.
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h80, 1'b1);
		send_beat(8'hC8, 1'b1);
		// Radius zero passes every pixel straight through.
		write_radius(RAD_W'(0));
		send_beat(8'h55, 1'b0);
		send_beat(8'hAA, 1'b1);
		// Widest window with lines shorter than the radius.
		write_radius(RAD_W'(MAX_RADIUS));
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b1);
		send_beat(8'h01, 1'b1);
		// A radius write in the middle of a line drops that line.
		write_radius(RAD_W'(3));
		send_beat(8'd10, 1'b0);
		send_beat(8'd20, 1'b0);
		send_beat(8'd30, 1'b0);
		send_beat(8'd40, 1'b0);
		send_beat(8'd50, 1'b0);
		write_radius(RAD_W'(2));
		send_beat(8'd7, 1'b0);
		send_beat(8'd8, 1'b0);
		send_beat(8'd9, 1'b1);

		// Back-pressure: results held off while pixels keep coming back to back.
		write_radius(RAD_W'(2));
		tx_fast = 1'b1;
		rx_hold = 80;
		send_line(50, 1'b1);
		tx_fast = 1'b0;

		while (pixels_sent < ITEMS) begin
			case ($urandom_range(0, 7))
				0:       r = RAD_W'(0);
				1:       r = RAD_W'(MAX_RADIUS);
				default: r = RAD_W'($urandom_range(0, 15));
			endcase
			write_radius(r);
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			lines = $urandom_range(1, 4);
			for (int i = 0; i < lines; i++) begin
				if (pixels_sent >= ITEMS)
					break;
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(1, 40);
				else
					len = $urandom_range(1, 2 * int'(r) + 4);
				// Now and then a line is cut off and the next radius write abandons it.
				if ($urandom_range(0, 9) == 0) begin
					send_line(len, 1'b0);
					break;
				end
				send_line(len, 1'b1);
			end
		end

		settle();
		$display("Sent %0d pixels in %0d complete lines over %0d radius writes.",
			pixels_sent, lines_sent, radius_writes);
		$display("Checked %0d filtered beats, %0d mismatches.", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("line_box_filter test passed");
		else
			$display("line_box_filter test failed");
		$finish;
	end

endmodule
